### sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OCC_W        = 5;
  localparam int unsigned DEF_CAPACITY = 16;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ENQ,
    OP_DEQ,
    OP_ROT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       load;
    logic       entry_valid;
    logic       last;
    logic [1:0] status;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic single;
  } spq_stat_t;

endpackage

### sv/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  spq_stat_t     stat_i,
  input  logic [CW-1:0] count_i,
  output spq_cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] remain_q, remain_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic          accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    remain_d     = remain_q;
    cmd_o        = '{op: OP_NOP, load: 1'b0, entry_valid: 1'b0, last: 1'b1,
                     status: STATUS_OK};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (cmd_i)
            CMD_ENQ: begin
              if (stat_i.full) cmd_o.status = STATUS_FULL;
              else cmd_o.op = OP_ENQ;
            end
            CMD_DEQ: begin
              if (stat_i.empty) cmd_o.status = STATUS_EMPTY;
              else cmd_o.op = OP_DEQ;
            end
            CMD_DUMP: begin
              if (!stat_i.empty) begin
                // first entry goes out with the transaction, the rest follow
                cmd_o.op          = OP_ROT;
                cmd_o.entry_valid = 1'b1;
                cmd_o.last        = stat_i.single;
                if (!stat_i.single) begin
                  state_d  = ST_DUMP;
                  remain_d = count_i - CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd_o.load        = 1'b1;
          cmd_o.op          = OP_ROT;
          cmd_o.entry_valid = 1'b1;
          cmd_o.last        = (remain_q == CW'(1));
          remain_d          = remain_q - CW'(1);
          if (remain_q == CW'(1)) state_d = ST_IDLE;
        end
      end
      default: ;
    endcase
    out_valid_d = cmd_o.load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/spq_datapath.sv
module spq_datapath import spq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spq_cmd_t                 cmd_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  input  logic signed [DATA_W-1:0] item_priority_i,
  output spq_stat_t                stat_o,
  output logic [CW-1:0]            count_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic signed [DATA_W-1:0] out_priority_o,
  output logic                     entry_valid_o,
  output logic                     last_o,
  output logic [OCC_W-1:0]         occupancy_o,
  output logic [1:0]               status_o
);

  logic signed [DATA_W-1:0] val_q [CAPACITY];
  logic signed [DATA_W-1:0] pri_q [CAPACITY];
  logic [CAPACITY-1:0]      ge;
  logic [CW-1:0]            count_q, count_d;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(i);
    localparam logic [CW-1:0] IDX1 = CW'(i + 1);
    logic                     boundary;
    logic signed [DATA_W-1:0] prev_val, prev_pri, next_val, next_pri;
    logic signed [DATA_W-1:0] val_d, pri_d;

    assign ge[i] = (IDX < count_q) && (pri_q[i] >= item_priority_i);

    if (i == 0) begin : g_first
      assign boundary = 1'b1;
      assign prev_val = item_value_i;
      assign prev_pri = item_priority_i;
    end else begin : g_inner
      assign boundary = ge[i-1];
      assign prev_val = val_q[i-1];
      assign prev_pri = pri_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = val_q[i];
      assign next_pri = pri_q[i];
    end else begin : g_body
      assign next_val = val_q[i+1];
      assign next_pri = pri_q[i+1];
    end

    always_comb begin
      val_d = val_q[i];
      pri_d = pri_q[i];
      unique case (cmd_i.op)
        OP_ENQ: begin
          // entries at or above the new priority stay, the rest move back one
          if (!ge[i]) begin
            if (boundary) begin
              val_d = item_value_i;
              pri_d = item_priority_i;
            end else begin
              val_d = prev_val;
              pri_d = prev_pri;
            end
          end
        end
        OP_DEQ: begin
          val_d = next_val;
          pri_d = next_pri;
        end
        OP_ROT: begin
          // head wraps round to the last occupied cell
          if (IDX1 == count_q) begin
            val_d = val_q[0];
            pri_d = pri_q[0];
          end else begin
            val_d = next_val;
            pri_d = next_pri;
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk_i) begin
      val_q[i] <= val_d;
      pri_q[i] <= pri_d;
    end
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_ENQ:  count_d = count_q + CW'(1);
      OP_DEQ:  count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_value_o    <= cmd_i.entry_valid ? val_q[0] : '0;
      out_priority_o <= cmd_i.entry_valid ? pri_q[0] : '0;
      entry_valid_o  <= cmd_i.entry_valid;
      last_o         <= cmd_i.last;
      occupancy_o    <= OCC_W'(count_d);
      status_o       <= cmd_i.status;
    end
  end

  assign stat_o.full   = (count_q == CW'(CAPACITY));
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.single = (count_q == CW'(1));
  assign count_o       = count_q;

endmodule

### sv/sorted_priority_queue.sv
// a result is shown in the cycle after its transaction is accepted
// enqueue and dequeue act on all compare-and-shift cells in parallel
// a dump gives one result per held entry, the store rotating one cell per result
// a new transaction is taken once the output register is free and no dump is running
// reset (rst_ni, asynchronous, active low) empties the queue and clears the output valid
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  input  logic signed [DATA_W-1:0] item_priority_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic signed [DATA_W-1:0] out_priority_o,
  output logic                     entry_valid_o,
  output logic                     last_o,
  output logic [OCC_W-1:0]         occupancy_o,
  output logic [1:0]               status_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_cmd_t      cmd;
  spq_stat_t     stat;
  logic [CW-1:0] count;

  spq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .count_i     (count),
    .cmd_o       (cmd)
  );

  spq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .stat_o          (stat),
    .count_o         (count),
    .out_value_o     (out_value_o),
    .out_priority_o  (out_priority_o),
    .entry_valid_o   (entry_valid_o),
    .last_o          (last_o),
    .occupancy_o     (occupancy_o),
    .status_o        (status_o)
  );

endmodule

### sv/spq_checker.sv
module spq_checker import spq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] out_value_o,
  input logic signed [DATA_W-1:0] out_priority_o,
  input logic                     entry_valid_o,
  input logic                     last_o,
  input logic [OCC_W-1:0]         occupancy_o,
  input logic [1:0]               status_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o)
      && $stable(last_o) && $stable(entry_valid_o))
    else $error("stalled result changed");

  a_dropped_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> occupancy_o == OCC_W'(CAPACITY))
    else $error("enqueue dropped while not full");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_EMPTY) |-> occupancy_o == '0 && last_o)
    else $error("empty dequeue with entries held");

  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_o && out_value_o == '0
      && out_priority_o == '0)
    else $error("non-entry result not final or not zero");

  // occupancy is masked to its width, so it reads zero when a multiple of 32 entries is held
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> status_o == STATUS_OK
      && (occupancy_o != '0 || CAPACITY >= 32))
    else $error("dumped entry with bad status");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
